// File: design/spq_pkg.sv
`timescale 1ns / 1ps
// Shared codes and types for the sorted priority queue.
// No dependencies; imported by spq_cell and sorted_priority_queue.
package spq_pkg;

   // Operation codes on req_func
   localparam logic [1:0] FUNC_ENQUEUE = 2'd0;
   localparam logic [1:0] FUNC_DEQUEUE = 2'd1;
   localparam logic [1:0] FUNC_PEEK    = 2'd2;

   // Status codes on rsp_status
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // Per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic push;   // insert the new entry, shift the tail down by one
      logic pop;    // drop the head, shift every entry up by one
   } cell_ctrl_type;

endpackage

// File: design/sorted_priority_queue.sv
`timescale 1ns / 1ps
// Sorted priority queue: a chain of DEPTH spq_cell slots, head in slot 0.
// The result is registered in the cycle after the request transfer.
// Throughput: one enqueue, dequeue or peek per cycle if rsp_ready allows; every
// slot compares and shifts in parallel in the same cycle, so no operation waits on the chain.
// Reset (synchronous, active high) empties the queue and clears rsp_valid;
// slot contents and result data are not cleared and are never read beyond the entry count.
module sorted_priority_queue #(
   parameter int DEPTH         = 16,
   parameter int TAG_BITS      = 16,
   parameter int PRIORITY_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_func,
   input  logic [TAG_BITS - 1:0]             req_entry_tag,
   input  logic [PRIORITY_BITS - 1:0]        req_entry_priority,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic [TAG_BITS - 1:0]             rsp_head_tag,
   output logic [PRIORITY_BITS - 1:0]        rsp_head_priority,
   output logic [$clog2(DEPTH + 1) - 1:0]    rsp_occupancy
);
   import spq_pkg::*;

   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [CNT_BITS - 1:0]      count_ff;
   logic [CNT_BITS - 1:0]      count_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [1:0]                 status_ff;
   logic [1:0]                 status_in;
   logic [TAG_BITS - 1:0]      head_tag_ff;
   logic [TAG_BITS - 1:0]      head_tag_in;
   logic [PRIORITY_BITS - 1:0] head_prio_ff;
   logic [PRIORITY_BITS - 1:0] head_prio_in;
   logic [CNT_BITS - 1:0]      occ_ff;

   logic                       accept;
   logic                       full;
   logic                       empty;
   cell_ctrl_type              ctrl;

   logic [TAG_BITS - 1:0]      tag_w  [DEPTH];
   logic [PRIORITY_BITS - 1:0] prio_w [DEPTH];
   logic                       gt_w   [DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = count_ff == CNT_BITS'(DEPTH);
   assign empty     = count_ff == '0;

   assign ctrl.push = accept && (req_func == FUNC_ENQUEUE) && !full;
   assign ctrl.pop  = accept && (req_func == FUNC_DEQUEUE) && !empty;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_cell #(
         .INDEX         (i),
         .DEPTH         (DEPTH),
         .TAG_BITS      (TAG_BITS),
         .PRIORITY_BITS (PRIORITY_BITS)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .count     (count_ff),
         .new_tag   (req_entry_tag),
         .new_prio  (req_entry_priority),
         .prev_tag  ((i == 0) ? req_entry_tag      : tag_w[(i == 0) ? 0 : i - 1]),
         .prev_prio ((i == 0) ? req_entry_priority : prio_w[(i == 0) ? 0 : i - 1]),
         .prev_gt   ((i == 0) ? 1'b0               : gt_w[(i == 0) ? 0 : i - 1]),
         .next_tag  (tag_w[(i == DEPTH - 1) ? i : i + 1]),
         .next_prio (prio_w[(i == DEPTH - 1) ? i : i + 1]),
         .tag       (tag_w[i]),
         .prio      (prio_w[i]),
         .gt        (gt_w[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      status_in    = STATUS_OK;
      head_tag_in  = '0;
      head_prio_in = '0;
      case (req_func)
         FUNC_ENQUEUE: begin
            if (full) status_in = STATUS_FULL;
         end
         FUNC_DEQUEUE, FUNC_PEEK: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               head_tag_in  = tag_w[0];
               head_prio_in = prio_w[0];
            end
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   // Hold the result until taken; a new transfer may replace it in the same cycle
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         head_tag_ff  <= head_tag_in;
         head_prio_ff <= head_prio_in;
         occ_ff       <= count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_head_tag      = head_tag_ff;
   assign rsp_head_priority = head_prio_ff;
   assign rsp_occupancy     = occ_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("entry count above depth");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.push |=> count_ff == $past(count_ff) + 1'b1)
      else $error("enqueue did not grow the queue");

   a_head_order: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CNT_BITS'(2) |-> prio_w[0] >= prio_w[1])
      else $error("head priority below second entry");

   a_empty_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == STATUS_EMPTY |-> occ_ff == '0 && head_tag_ff == '0)
      else $error("empty response with entries or tag");

endmodule

// File: design/spq_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted chain: holds a tag and a priority and trades
// them with its neighbours. Depends on spq_pkg.
module spq_cell #(
   parameter int INDEX         = 0,
   parameter int DEPTH         = 16,
   parameter int TAG_BITS      = 16,
   parameter int PRIORITY_BITS = 8
) (
   input  logic                              clock,
   input  spq_pkg::cell_ctrl_type            ctrl,
   input  logic [$clog2(DEPTH + 1) - 1:0]    count,
   input  logic [TAG_BITS - 1:0]             new_tag,
   input  logic [PRIORITY_BITS - 1:0]        new_prio,
   input  logic [TAG_BITS - 1:0]             prev_tag,
   input  logic [PRIORITY_BITS - 1:0]        prev_prio,
   input  logic                              prev_gt,
   input  logic [TAG_BITS - 1:0]             next_tag,
   input  logic [PRIORITY_BITS - 1:0]        next_prio,
   output logic [TAG_BITS - 1:0]             tag,
   output logic [PRIORITY_BITS - 1:0]        prio,
   output logic                              gt
);
   import spq_pkg::*;

   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [TAG_BITS - 1:0]      tag_ff;
   logic [TAG_BITS - 1:0]      tag_in;
   logic [PRIORITY_BITS - 1:0] prio_ff;
   logic [PRIORITY_BITS - 1:0] prio_in;
   logic                       occupied;

   assign occupied = count > CNT_BITS'(INDEX);
   // Stored entry stays ahead of the newcomer only if strictly higher
   assign gt       = occupied && (prio_ff > new_prio);

   always_comb begin
      tag_in  = tag_ff;
      prio_in = prio_ff;
      if (ctrl.push) begin
         if (!gt) begin
            if (prev_gt) begin
               tag_in  = new_tag;
               prio_in = new_prio;
            end else begin
               tag_in  = prev_tag;
               prio_in = prev_prio;
            end
         end
      end else if (ctrl.pop) begin
         tag_in  = next_tag;
         prio_in = next_prio;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff  <= tag_in;
      prio_ff <= prio_in;
   end

   assign tag  = tag_ff;
   assign prio = prio_ff;

endmodule
